/* rtl/stack_machine_instruction_core_assert.svh */
// Assertion macros shared by the stack machine core RTL.
`ifndef STACK_MACHINE_INSTRUCTION_CORE_ASSERT_SVH
`define STACK_MACHINE_INSTRUCTION_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SMI_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack machine core: assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SMI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack machine core: assertion failed");

`endif

/* rtl/smi_pkg.sv */
// Package with opcodes, status codes and default sizes of the stack machine core.
package smi_pkg;

    localparam int STACK_DEPTH_DEF    = 32;
    localparam int SLOT_COUNT_DEF     = 8;
    localparam int CODE_ADDR_BITS_DEF = 16;

    localparam int DATA_W = 64;

    typedef enum logic [3:0] {
        OP_PUSH_IMM = 4'd0,
        OP_LOAD     = 4'd1,
        OP_PUT_SLOT = 4'd2,
        OP_ADD      = 4'd3,
        OP_SUB      = 4'd4,
        OP_LE       = 4'd5,
        OP_JF       = 4'd6,
        OP_JMP      = 4'd7,
        OP_RET      = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_SLOT  = 3'd3,
        ST_OPC   = 3'd4
    } status_t;

endpackage

/* rtl/smi_stack_mem.sv */
// Operand stack memory: two registered read ports, one write port, write-to-read bypass.
module smi_stack_mem #(
    parameter int DEPTH  = smi_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W = $clog2(smi_pkg::STACK_DEPTH_DEF)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr_a,
    input  logic [ADDR_W-1:0]         rd_addr_b,
    output logic [smi_pkg::DATA_W-1:0] rd_data_a,
    output logic [smi_pkg::DATA_W-1:0] rd_data_b,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [smi_pkg::DATA_W-1:0] wr_data
);

    logic [smi_pkg::DATA_W-1:0] mem [DEPTH];
    logic [smi_pkg::DATA_W-1:0] mem_a_reg;
    logic [smi_pkg::DATA_W-1:0] mem_b_reg;
    logic [smi_pkg::DATA_W-1:0] fwd_reg;
    logic                       hit_a_reg;
    logic                       hit_b_reg;

    // The array returns the old contents when read and written at one edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_a_reg <= mem[rd_addr_a];
            mem_b_reg <= mem[rd_addr_b];
            fwd_reg   <= wr_data;
        end
    end

    // A write landing at the same edge as a read of the same entry is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_a_reg <= wr_en && (wr_addr == rd_addr_a);
            hit_b_reg <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    assign rd_data_a = hit_a_reg ? fwd_reg : mem_a_reg;
    assign rd_data_b = hit_b_reg ? fwd_reg : mem_b_reg;

endmodule

/* rtl/smi_slot_mem.sv */
// Local slot memory with per-entry valid bits, bulk clear and write-to-read bypass.
`include "stack_machine_instruction_core_assert.svh"

module smi_slot_mem #(
    parameter int SLOT_COUNT = smi_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = $clog2(smi_pkg::SLOT_COUNT_DEF)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic [smi_pkg::DATA_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_idx,
    input  logic [smi_pkg::DATA_W-1:0] wr_data,
    input  logic                       clr
);

    logic [smi_pkg::DATA_W-1:0] mem [SLOT_COUNT];
    logic [smi_pkg::DATA_W-1:0] mem_rd_reg;
    logic [smi_pkg::DATA_W-1:0] fwd_reg;
    logic [SLOT_COUNT-1:0]      valid_reg;
    logic [SLOT_COUNT-1:0]      valid_next;
    logic                       rd_valid_reg;
    logic                       hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_idx];
            fwd_reg    <= wr_data;
        end
    end

    // A clear wins over a write at the same edge: the clearing word comes later.
    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
                hit_reg      <= wr_en && !clr && (wr_idx == rd_idx);
            end
        end
    end

    // A slot never written since reset or the last clear reads as zero.
    assign rd_data = hit_reg      ? fwd_reg :
                     rd_valid_reg ? mem_rd_reg : '0;

    `SMI_ASSERT_NEXT(a_clear_empties, clr, valid_reg == '0)

endmodule

/* rtl/stack_machine_instruction_core.sv */
// Top level of the bytecode stack machine core: decode, execute and result register.
//
// The input channel (in_valid, in_ready) takes one instruction word per handshake:
// an opcode byte and its operand byte. The output channel (out_valid, out_ready)
// gives one result word per instruction: the next fetch address, a return flag,
// the value popped by a return and a status code. Results come out in order.
//
// An instruction is decoded in the cycle it is accepted: faults, the new stack
// depth and all memory read addresses depend only on the opcode, the operand and
// the depth, so the stack and slot memories are read at that edge. When the
// execute stage advances, it combines the read data, writes back to the memories
// and loads the result register, which raises out_valid. Throughput is one
// instruction per cycle while out_ready is not held low; the read-to-write loop
// through the registered-read memories is closed by forwarding in each memory.
//
// When the receiver holds out_ready low, one more instruction is taken into the
// execute stage and then in_ready drops until the result register drains.
// Reset empties the stack, zeroes all local slots (through valid bits), sets the
// instruction address to zero and leaves both channels empty; the stack memory
// itself is not cleared, since only entries below the depth are ever read.
`include "stack_machine_instruction_core_assert.svh"

module stack_machine_instruction_core #(
    parameter int STACK_DEPTH    = smi_pkg::STACK_DEPTH_DEF,
    parameter int SLOT_COUNT     = smi_pkg::SLOT_COUNT_DEF,
    parameter int CODE_ADDR_BITS = smi_pkg::CODE_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  opcode,
    input  logic [7:0]  operand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_address,
    output logic        returned,
    output logic [63:0] return_value,
    output logic [2:0]  status
);

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SL_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DW    = smi_pkg::DATA_W;

    typedef logic [CODE_ADDR_BITS-1:0] addr_t;

    // Execute stage contents, captured at acceptance.
    typedef struct packed {
        smi_pkg::op_t     op;
        logic [7:0]       arg;
        smi_pkg::status_t st;
        logic [SA_W-1:0]  stack_waddr;
        logic [SL_W-1:0]  slot_idx;
    } exec_t;

    // Decode -------------------------------------------------------------------

    logic             in_accept;
    logic             x_valid_reg;
    logic             x_adv;
    exec_t            x_reg;
    exec_t            dec;
    logic [SP_W-1:0]  sp_reg;
    logic [SP_W-1:0]  sp_next;
    logic [SP_W-1:0]  sp_m1;
    logic [SP_W-1:0]  sp_m2;
    logic             op_known;
    logic             slot_bad;
    logic             slot_clr;

    assign in_ready  = !x_valid_reg || x_adv;
    assign in_accept = in_valid && in_ready;

    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign op_known = (opcode[7:4] == 4'd0) && (opcode[3:0] <= smi_pkg::OP_RET);
    assign slot_bad = (opcode inside {8'(smi_pkg::OP_LOAD), 8'(smi_pkg::OP_PUT_SLOT)})
                      && ({1'b0, operand} >= 9'(SLOT_COUNT));

    always_comb
    begin
        dec.op          = op_known ? smi_pkg::op_t'(opcode[3:0]) : smi_pkg::OP_PUSH_IMM;
        dec.arg         = operand;
        dec.st          = smi_pkg::ST_OK;
        dec.stack_waddr = sp_reg[SA_W-1:0];
        dec.slot_idx    = operand[SL_W-1:0];
        sp_next         = sp_reg;
        slot_clr        = 1'b0;
        if (!op_known)
        begin
            dec.st = smi_pkg::ST_OPC;
        end
        else if (slot_bad)
        begin
            dec.st = smi_pkg::ST_SLOT;
        end
        else
        begin
            case (dec.op)
                smi_pkg::OP_PUSH_IMM, smi_pkg::OP_LOAD:
                begin
                    if (sp_reg >= SP_W'(STACK_DEPTH))
                    begin
                        dec.st = smi_pkg::ST_OVER;
                    end
                    else
                    begin
                        sp_next = sp_reg + SP_W'(1);
                    end
                end
                smi_pkg::OP_PUT_SLOT, smi_pkg::OP_JF:
                begin
                    if (sp_reg == '0)
                    begin
                        dec.st = smi_pkg::ST_UNDER;
                    end
                    else
                    begin
                        sp_next = sp_m1;
                    end
                end
                smi_pkg::OP_ADD, smi_pkg::OP_SUB, smi_pkg::OP_LE:
                begin
                    dec.stack_waddr = sp_m2[SA_W-1:0];
                    if (sp_reg < SP_W'(2))
                    begin
                        dec.st = smi_pkg::ST_UNDER;
                    end
                    else
                    begin
                        sp_next = sp_m1;
                    end
                end
                smi_pkg::OP_RET:
                begin
                    if (sp_reg == '0)
                    begin
                        dec.st = smi_pkg::ST_UNDER;
                    end
                    else
                    begin
                        sp_next  = '0;
                        slot_clr = 1'b1;
                    end
                end
                default:
                begin
                    sp_next = sp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            x_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                sp_reg <= sp_next;
            end
            if (in_accept)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (x_adv)
            begin
                x_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= dec;
        end
    end

    // Memories -----------------------------------------------------------------

    logic [DW-1:0] top_data;     // entry at depth minus one
    logic [DW-1:0] second_data;  // entry at depth minus two
    logic [DW-1:0] slot_data;
    logic [DW-1:0] stack_wdata;
    logic          stack_we;
    logic          slot_we;

    smi_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (SA_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (sp_m1[SA_W-1:0]),
        .rd_addr_b (sp_m2[SA_W-1:0]),
        .rd_data_a (top_data),
        .rd_data_b (second_data),
        .wr_en     (stack_we),
        .wr_addr   (x_reg.stack_waddr),
        .wr_data   (stack_wdata)
    );

    smi_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (SL_W)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_idx  (dec.slot_idx),
        .rd_data (slot_data),
        .wr_en   (slot_we),
        .wr_idx  (x_reg.slot_idx),
        .wr_data (top_data),
        .clr     (in_accept && slot_clr)
    );

    // Execute ------------------------------------------------------------------

    logic                    out_valid_reg;
    logic                    x_ok;
    addr_t                   addr_reg;
    addr_t                   addr_next;
    addr_t                   after1;
    addr_t                   after2;
    addr_t                   target;
    logic [CODE_ADDR_BITS+15:0] addr_wide;
    logic                    ret_next;
    logic [DW-1:0]           retval_next;

    assign x_adv  = x_valid_reg && (!out_valid_reg || out_ready);
    assign x_ok   = (x_reg.st == smi_pkg::ST_OK);
    assign after1 = addr_reg + addr_t'(1);
    assign after2 = addr_reg + addr_t'(2);
    assign target = after2 + addr_t'($signed(x_reg.arg));

    always_comb
    begin
        stack_wdata = '0;
        stack_we    = 1'b0;
        slot_we     = 1'b0;
        addr_next   = addr_reg;
        ret_next    = 1'b0;
        retval_next = '0;
        if (x_ok)
        begin
            case (x_reg.op)
                smi_pkg::OP_PUSH_IMM:
                begin
                    stack_wdata = DW'(x_reg.arg);
                    stack_we    = x_adv;
                    addr_next   = after2;
                end
                smi_pkg::OP_LOAD:
                begin
                    stack_wdata = slot_data;
                    stack_we    = x_adv;
                    addr_next   = after2;
                end
                smi_pkg::OP_PUT_SLOT:
                begin
                    slot_we   = x_adv;
                    addr_next = after2;
                end
                smi_pkg::OP_ADD:
                begin
                    stack_wdata = second_data + top_data;
                    stack_we    = x_adv;
                    addr_next   = after1;
                end
                smi_pkg::OP_SUB:
                begin
                    stack_wdata = second_data - top_data;
                    stack_we    = x_adv;
                    addr_next   = after1;
                end
                smi_pkg::OP_LE:
                begin
                    stack_wdata = DW'($signed(second_data) <= $signed(top_data));
                    stack_we    = x_adv;
                    addr_next   = after1;
                end
                smi_pkg::OP_JF:
                begin
                    addr_next = (top_data == '0) ? target : after2;
                end
                smi_pkg::OP_JMP:
                begin
                    addr_next = target;
                end
                smi_pkg::OP_RET:
                begin
                    addr_next   = '0;
                    ret_next    = 1'b1;
                    retval_next = top_data;
                end
                default:
                begin
                    addr_next = addr_reg;
                end
            endcase
        end
    end

    // The port carries the low sixteen address bits, zero-extended if narrower.
    assign addr_wide = {16'b0, addr_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (x_adv)
            begin
                addr_reg      <= addr_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_adv)
        begin
            next_address <= addr_wide[15:0];
            returned     <= ret_next;
            return_value <= retval_next;
            status       <= x_reg.st;
        end
    end

    assign out_valid = out_valid_reg;

    `SMI_ASSERT_IMPLIES(a_depth_bound, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `SMI_ASSERT_IMPLIES(a_return_clean, out_valid && returned,
                        status == smi_pkg::ST_OK && next_address == 16'd0)
    `SMI_ASSERT_IMPLIES(a_fault_quiet, out_valid && status != smi_pkg::ST_OK,
                        !returned && return_value == 64'd0)
    `SMI_ASSERT_NEXT(a_exec_holds, x_valid_reg && !x_adv, x_valid_reg)

endmodule
